@@ src/deq_pkg.sv @@
// types and codes shared by the double-ended queue modules
package deq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               has_element;
		logic signed [31:0] element;
		logic               last;
		logic [6:0]         occupancy;
	} rsp_beat_t;

	// controller to datapath
	typedef struct packed {
		logic    load_simple;
		status_t status;
		logic    push_front;
		logic    push_rear;
		logic    pop_front;
		logic    pop_rear;
		logic    start_dump;
		logic    rd_issue;
		logic    s1_move;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic out_valid;
		logic s1_valid;
		logic s1_last;
		logic rd_left_zero;
	} dp_stat_t;

endpackage

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values, CAPACITY entries.
// Command channel: cmd_valid / cmd_stall / cmd carries one command per beat
// (push front, push rear, pop front, pop rear, dump) and a value to push.
// Response channel: rsp_valid / rsp_stall / rsp carries status, the dumped
// element with its has_element flag, a last marker and the occupancy.
// Push, pop and unused codes give one response, in the cycle after the
// command beat; they are taken back to back, one per cycle, while rsp_stall
// is low. A dump of N stored entries gives N responses, front to rear, via
// the read stage and the output register, one per cycle while rsp_stall is
// low; the single read port of the entry store paces this, and no command
// is taken until the final dump response has entered the output register.
// A dump of an empty store gives one response with last set.
// Reset empties the queue (head and count cleared); store contents are not
// cleared and need no clearing pass, as only written slots are read.
// While rsp_stall is high the response register holds, and cmd_stall rises
// once it is full, so nothing is lost or repeated.
module double_ended_queue import deq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd_stall (cmd_stall),
		.ctl       (ctl)
	);

	deq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (cmd.value),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

@@ src/deq_ctrl.sv @@
// controller: command decode and dump sequencing
module deq_ctrl import deq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic [2:0] command,
	input  logic      rsp_stall,
	input  dp_stat_t  stat,
	output logic      cmd_stall,
	output dp_cmd_t   ctl
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   can_load;
	logic   accept;

	// output register free now or emptied this cycle
	assign can_load = !stat.out_valid || !rsp_stall;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.status = ST_OK;
		accept = 1'b0;
		cmd_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				cmd_stall = !can_load;
				accept = cmd_valid && can_load;
				if (accept) begin
					case (command)
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							ctl.load_simple = 1'b1;
							if (stat.full) begin
								ctl.status = ST_OVERFLOW;
							end else if (command == OP_PUSH_FRONT) begin
								ctl.push_front = 1'b1;
							end else begin
								ctl.push_rear = 1'b1;
							end
						end
						OP_POP_FRONT, OP_POP_REAR: begin
							ctl.load_simple = 1'b1;
							if (stat.empty) begin
								ctl.status = ST_UNDERFLOW;
							end else if (command == OP_POP_FRONT) begin
								ctl.pop_front = 1'b1;
							end else begin
								ctl.pop_rear = 1'b1;
							end
						end
						OP_DUMP: begin
							if (stat.empty) begin
								ctl.load_simple = 1'b1;
							end else begin
								ctl.start_dump = 1'b1;
								state_d = S_DUMP;
							end
						end
						default: begin
							ctl.load_simple = 1'b1;
						end
					endcase
				end
			end
			S_DUMP: begin
				ctl.s1_move = stat.s1_valid && can_load;
				ctl.rd_issue = !stat.rd_left_zero && (!stat.s1_valid || ctl.s1_move);
				if (ctl.s1_move && stat.s1_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/deq_dp.sv @@
// datapath: circular store, head and count, dump read stage, output register
module deq_dp import deq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  logic               rsp_stall,
	input  dp_cmd_t            ctl,
	output dp_stat_t           stat,
	output logic               rsp_valid,
	output rsp_beat_t          rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic signed [31:0] mem [CAPACITY];

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   rd_left_q;
	logic signed [31:0] rd_data_s1;
	logic               valid_s1;
	logic               last_s1;
	logic               out_valid_q;
	rsp_beat_t          out_q;

	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] rd_ptr_inc;
	logic [SUM_W-1:0] rear_sum;
	logic [IDX_W-1:0] rear_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;

	assign head_dec   = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;

	// slot one past the rear, wrapped; the sum stays below twice the capacity
	assign rear_sum = SUM_W'(head_q) + SUM_W'(count_q);
	always_comb begin
		if (rear_sum >= CAP_S) begin
			rear_idx = IDX_W'(rear_sum - CAP_S);
		end else begin
			rear_idx = IDX_W'(rear_sum);
		end
	end

	assign wr_en   = ctl.push_front || ctl.push_rear;
	assign wr_addr = ctl.push_front ? head_dec : rear_idx;

	always_comb begin
		count_d = count_q;
		if (wr_en) begin
			count_d = count_q + 1'b1;
		end else if (ctl.pop_front || ctl.pop_rear) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (ctl.rd_issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			rd_left_q <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctl.push_front) begin
				head_q <= head_dec;
			end else if (ctl.pop_front) begin
				head_q <= head_inc;
			end
			if (ctl.start_dump) begin
				rd_ptr_q  <= head_q;
				rd_left_q <= count_q;
			end else if (ctl.rd_issue) begin
				rd_ptr_q  <= rd_ptr_inc;
				rd_left_q <= rd_left_q - 1'b1;
			end
			if (ctl.rd_issue) begin
				valid_s1 <= 1'b1;
				last_s1  <= (rd_left_q == CNT_W'(1));
			end else if (ctl.s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_simple || ctl.s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_simple) begin
			out_q.status      <= ctl.status;
			out_q.has_element <= 1'b0;
			out_q.element     <= '0;
			out_q.last        <= 1'b1;
			out_q.occupancy   <= 7'(count_d);
		end else if (ctl.s1_move) begin
			out_q.status      <= ST_OK;
			out_q.has_element <= 1'b1;
			out_q.element     <= rd_data_s1;
			out_q.last        <= last_s1;
			out_q.occupancy   <= 7'(count_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign stat.full         = (count_q == CAP_C);
	assign stat.empty        = (count_q == '0);
	assign stat.out_valid    = out_valid_q;
	assign stat.s1_valid     = valid_s1;
	assign stat.s1_last      = last_s1;
	assign stat.rd_left_zero = (rd_left_q == '0);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the double-ended queue: directed corners, fill and drain, random mix
`timescale 1ns / 1ps

module testbench;
	import deq_pkg::*;

	localparam int DEPTH      = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int PRINT_CAP  = 100;

	// command codes that the block ignores
	localparam logic [2:0] SPARE_CODE_FIRST = 3'd5;
	localparam logic [2:0] SPARE_CODE_LAST  = 3'd7;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_beat_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// shadow copy of the queue contents
	logic signed [31:0] shadow_mem [DEPTH];
	int                 shadow_head = 0;
	int                 shadow_fill = 0;

	rsp_beat_t pending_rsp [$];
	int        mismatch_count = 0;
	int        burst_left     = 0;
	int        quiet_cycles   = 0;
	logic [9:0] stall_tick    = '0;

	always #2 clk = ~clk;

	double_ended_queue #(
		.CAPACITY(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	function automatic rsp_beat_t make_rsp(status_t st, logic has, logic signed [31:0] el,
			logic fin);
		rsp_beat_t r;
		r.status      = st;
		r.has_element = has;
		r.element     = el;
		r.last        = fin;
		r.occupancy   = 7'(shadow_fill);
		return r;
	endfunction

	task automatic queue_outcome(input cmd_beat_t b);
		int k;
		case (b.command)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (shadow_fill >= DEPTH) begin
					pending_rsp.push_back(make_rsp(ST_OVERFLOW, 1'b0, '0, 1'b1));
				end else begin
					if (b.command == OP_PUSH_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						shadow_mem[shadow_head] = b.value;
					end else begin
						shadow_mem[(shadow_head + shadow_fill) % DEPTH] = b.value;
					end
					shadow_fill++;
					pending_rsp.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (shadow_fill == 0) begin
					pending_rsp.push_back(make_rsp(ST_UNDERFLOW, 1'b0, '0, 1'b1));
				end else begin
					if (b.command == OP_POP_FRONT)
						shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
					pending_rsp.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
				end
			end
			OP_DUMP: begin
				if (shadow_fill == 0) begin
					pending_rsp.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
				end else begin
					for (k = 0; k < shadow_fill; k++)
						pending_rsp.push_back(make_rsp(ST_OK, 1'b1,
							shadow_mem[(shadow_head + k) % DEPTH], k == shadow_fill - 1));
				end
			end
			default: begin
				pending_rsp.push_back(make_rsp(ST_OK, 1'b0, '0, 1'b1));
			end
		endcase
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// bursts of back-to-back beats with random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic send_item(input logic [2:0] code, input logic signed [31:0] val);
		cmd_beat_t b;
		b.command = code;
		b.value   = val;
		cmd_valid <= 1'b1;
		cmd       <= b;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		queue_outcome(b);
		pace_sender();
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: %s got %h want %h", $time, what, got, want);
	endtask

	task automatic test_corner_cases();
		logic [2:0] code;
		send_item(OP_DUMP, rand_value());
		send_item(OP_POP_FRONT, rand_value());
		send_item(OP_POP_REAR, rand_value());
		// first front push wraps the head below zero
		send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
		send_item(OP_PUSH_REAR, 32'h8000_0000);
		send_item(OP_PUSH_FRONT, 32'h0000_0000);
		send_item(OP_PUSH_REAR, 32'hffff_ffff);
		send_item(OP_PUSH_FRONT, 32'h5555_5555);
		send_item(OP_PUSH_REAR, 32'haaaa_aaaa);
		send_item(OP_DUMP, 32'hffff_ffff);
		for (code = SPARE_CODE_FIRST; code <= SPARE_CODE_LAST && code != 3'd0; code++)
			send_item(code, rand_value());
		send_item(OP_POP_FRONT, 32'hffff_ffff);
		send_item(OP_POP_REAR, 32'h0000_0000);
		send_item(OP_DUMP, 32'h0000_0000);
		repeat (4) send_item($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, rand_value());
		send_item(OP_POP_FRONT, rand_value());
		send_item(OP_PUSH_REAR, 32'h0000_0001);
		// single entry dump carries last on its only beat
		send_item(OP_DUMP, rand_value());
		send_item(OP_POP_REAR, rand_value());
	endtask

	task automatic test_fill_and_drain();
		while (shadow_fill < DEPTH)
			send_item($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, rand_value());
		send_item(OP_PUSH_FRONT, rand_value());
		send_item(OP_PUSH_REAR, rand_value());
		wait_drained();
		send_item(OP_DUMP, rand_value());
		while (shadow_fill > 0)
			send_item($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, rand_value());
		send_item(OP_POP_FRONT, rand_value());
		send_item(OP_POP_REAR, rand_value());
		send_item(OP_DUMP, rand_value());
	endtask

	task automatic test_random_mix();
		int n;
		int r;
		int push_pct;
		push_pct = 50;
		for (n = 0; n < 240; n++) begin
			case (n)
				0:   push_pct = 85;
				60:  push_pct = 30;
				120: push_pct = 70;
				180: push_pct = 40;
				default: ;
			endcase
			if (n == 120)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < push_pct)
				send_item($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, rand_value());
			else if (r < 92)
				send_item($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, rand_value());
			else if (r < 97)
				send_item(OP_DUMP, rand_value());
			else
				send_item(3'($urandom_range(SPARE_CODE_FIRST, SPARE_CODE_LAST)), rand_value());
		end
	endtask

	// receiver stall pattern: quiet, sparse, periodic runs and coin-flip phases
	always @(posedge clk) begin
		stall_tick <= stall_tick + 10'd1;
		case (stall_tick[9:8])
			2'd0:    rsp_stall <= 1'b0;
			2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
			2'd2:    rsp_stall <= (stall_tick[2:0] >= 3'd5);
			default: rsp_stall <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("beat with nothing expected", rsp.element, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.has_element !== want.has_element)
					report_mismatch("has_element", 32'(rsp.has_element), 32'(want.has_element));
				if (rsp.element !== want.element)
					report_mismatch("element", rsp.element, want.element);
				if (rsp.last !== want.last)
					report_mismatch("last", 32'(rsp.last), 32'(want.last));
				if (rsp.occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_fill_and_drain();
		test_random_mix();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
